[sv/i2cm_pkg.sv]
package i2cm_pkg;

	// defaults and fixed field widths
	localparam int TICK_WIDTH_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int HALF_BIT_RESET = 300;

	// command codes as carried on the action field
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	// bus sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ST_REL = 4'd1,
		PH_ST_SDA = 4'd2,
		PH_ST_SCL = 4'd3,
		PH_BIT_LO = 4'd4,
		PH_BIT_HI = 4'd5,
		PH_SP_LOW = 4'd6,
		PH_SP_SCL = 4'd7,
		PH_SP_SDA = 4'd8
	} phase_t;

	// one classified tick waiting for the sequencer
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
		logic       nack;
		logic       sda;
	} item_t;

	// one result per tick
	typedef struct packed {
		logic       rejected;
		logic       slave_nack;
		logic [7:0] read_byte;
		logic       done;
		logic       busy;
		logic       sda_low;
		logic       scl;
	} result_t;

endpackage

[sv/i2cm_front.sv]
module i2cm_front
	import i2cm_pkg::*;
(
	input  logic [2:0] action,
	input  logic [7:0] data,
	input  logic       master_nack,
	input  logic       sda_line,
	output item_t      item
);

	// classify the action code, unused codes become a plain tick
	always_comb begin
		item.data = data;
		item.nack = master_nack;
		item.sda  = sda_line;
		if (action inside {CMD_START, CMD_WRITE, CMD_READ, CMD_STOP}) begin
			item.cmd = cmd_t'(action);
		end else begin
			item.cmd = CMD_NONE;
		end
	end

endmodule

[sv/i2cm_queue.sv]
module i2cm_queue
	import i2cm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/i2cm_back.sv]
module i2cm_back
	import i2cm_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             q_valid,
	output logic             q_ready,
	input  item_t            q_item,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam int LW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
	localparam longint unsigned MAX_HOLD = (64'd1 << TICK_WIDTH) - 64'd1;
	localparam logic [LW:0] MAX_HOLD_W = (LW+1)'(MAX_HOLD);
	localparam longint unsigned RST_HOLD_L =
		(HALF_BIT_RESET > MAX_HOLD) ? MAX_HOLD : HALF_BIT_RESET;
	localparam logic [TICK_WIDTH-1:0] RST_HOLD = TICK_WIDTH'(RST_HOLD_L);

	logic [TICK_WIDTH-1:0] hold_q;
	logic [LW:0]           lim_w;

	phase_t                phase_q, n_phase;
	cmd_t                  cmd_q, n_cmd;
	logic [3:0]            bit_q, n_bit;
	logic [7:0]            shift_q, n_shift;
	logic [TICK_WIDTH-1:0] tick_q, n_tick;
	logic                  ackc_q, n_ackc;
	logic                  scl_q, n_scl;
	logic                  sdal_q, n_sdal;
	logic                  acks_q, n_acks;
	logic [7:0]            read_q, n_read;
	logic                  ent, done, rej, expire, pop;
	logic [TICK_WIDTH:0]   tick_inc;

	logic                  out_valid_q;
	result_t               res_q;

	// effective hold count, zero acts as one and long holds saturate
	always_comb begin
		lim_w = (LW+1)'(cfg_wdata);
		if (lim_w == '0) lim_w = (LW+1)'(1);
		if (lim_w > MAX_HOLD_W) lim_w = MAX_HOLD_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= RST_HOLD;
		end else if (cfg_we) begin
			hold_q <= TICK_WIDTH'(lim_w);
		end
	end

	// a tick is taken when the output slot is free or being drained
	assign pop      = q_valid && (!out_valid_q || res_ready);
	assign q_ready  = pop;
	assign tick_inc = {1'b0, tick_q} + (TICK_WIDTH+1)'(1);
	assign expire   = (tick_inc >= {1'b0, hold_q});

	// sequencer next state
	always_comb begin
		n_phase = phase_q;
		n_cmd   = cmd_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_tick  = tick_q;
		n_ackc  = ackc_q;
		n_scl   = scl_q;
		n_sdal  = sdal_q;
		n_acks  = acks_q;
		n_read  = read_q;
		ent     = 1'b0;
		done    = 1'b0;
		rej     = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (q_item.cmd != CMD_NONE) begin
				n_cmd = q_item.cmd;
				n_bit = 4'd0;
				ent   = 1'b1;
				case (q_item.cmd)
					CMD_START: n_phase = PH_ST_REL;
					CMD_STOP:  n_phase = PH_SP_LOW;
					default: begin
						n_shift = (q_item.cmd == CMD_WRITE) ? q_item.data : 8'h00;
						if (q_item.cmd == CMD_READ) n_ackc = q_item.nack;
						n_phase = PH_BIT_LO;
					end
				endcase
			end
		end else begin
			rej = (q_item.cmd != CMD_NONE);
			if (expire) begin
				n_tick = '0;
				case (phase_q)
					PH_ST_REL: begin n_phase = PH_ST_SDA; ent = 1'b1; end
					PH_ST_SDA: begin n_phase = PH_ST_SCL; ent = 1'b1; end
					PH_SP_LOW: begin n_phase = PH_SP_SCL; ent = 1'b1; end
					PH_SP_SCL: begin n_phase = PH_SP_SDA; ent = 1'b1; end
					PH_BIT_LO: begin n_phase = PH_BIT_HI; ent = 1'b1; end
					PH_BIT_HI: begin
						if (!bit_q[3]) begin
							// data slot: shift and go to the next low phase
							if (cmd_q == CMD_WRITE) n_shift = {shift_q[6:0], 1'b0};
							else n_shift = {shift_q[6:0], q_item.sda};
							n_bit   = bit_q + 4'd1;
							n_phase = PH_BIT_LO;
							ent     = 1'b1;
						end else begin
							// acknowledge slot ends the byte
							if (cmd_q == CMD_WRITE) n_acks = q_item.sda;
							else n_read = shift_q;
							n_scl   = 1'b0;
							n_phase = PH_IDLE;
							done    = 1'b1;
						end
					end
					default: begin
						n_phase = PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end else begin
				n_tick = tick_inc[TICK_WIDTH-1:0];
			end
		end
		// line levels set on entry to a phase
		if (ent) begin
			n_tick = '0;
			case (n_phase)
				PH_ST_REL: begin n_scl = 1'b1; n_sdal = 1'b0; end
				PH_ST_SDA: n_sdal = 1'b1;
				PH_ST_SCL: n_scl = 1'b0;
				PH_BIT_LO: begin
					n_scl = 1'b0;
					if (n_cmd == CMD_WRITE) n_sdal = n_bit[3] ? 1'b0 : ~n_shift[7];
					else n_sdal = n_bit[3] ? ~n_ackc : 1'b0;
				end
				PH_BIT_HI: n_scl = 1'b1;
				PH_SP_LOW: begin n_scl = 1'b0; n_sdal = 1'b1; end
				PH_SP_SCL: n_scl = 1'b1;
				PH_SP_SDA: n_sdal = 1'b0;
				default: ;
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= CMD_NONE;
			bit_q   <= 4'd0;
			shift_q <= 8'h00;
			tick_q  <= '0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sdal_q  <= 1'b0;
			acks_q  <= 1'b0;
			read_q  <= 8'h00;
		end else if (pop) begin
			phase_q <= n_phase;
			cmd_q   <= n_cmd;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			tick_q  <= n_tick;
			ackc_q  <= n_ackc;
			scl_q   <= n_scl;
			sdal_q  <= n_sdal;
			acks_q  <= n_acks;
			read_q  <= n_read;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl        <= n_scl;
			res_q.sda_low    <= n_sdal;
			res_q.busy       <= (n_phase != PH_IDLE);
			res_q.done       <= done;
			res_q.read_byte  <= n_read;
			res_q.slave_nack <= n_acks;
			res_q.rejected   <= rej;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	// checks
	a_idle_no_reject: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (phase_q == PH_IDLE) |=> !res_q.rejected)
		else $error("command rejected while sequencer idle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done |-> !res_q.busy)
		else $error("completion reported while still busy");

	a_tick_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0))
		else $error("hold counter not cleared while idle");

	a_bit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bit_q <= 4'd8))
		else $error("bit slot index beyond acknowledge slot");

endmodule

[sv/i2c_master_bit_engine_unit.sv]
// channel    | dir | signals                          | contents
// s_axis     | in  | tvalid tready tdata[15:0] tuser  | one bus tick, optional command
// m_axis     | out | tvalid tready tdata[15:0]        | line drive and status per tick
// cfg        | in  | cfg_we cfg_wdata[15:0]           | half_bit_ticks
//
// one tick accepted per clock while the queue has room, each tick gives one result
// the input goes through a two-entry queue, the sequencer and an output register
// input stalls only when the queue is full, i.e. after the output has been held
// reset returns the sequencer to idle with SCL and SDA released, hold 300 ticks
// a command is held for half_bit_ticks ticks per bus phase, not clocks
module i2c_master_bit_engine_unit
	import i2cm_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // data[7:0], master_nack[8], sda_line[9], zero
	input  logic [2:0]       s_axis_tuser,  // action[2:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // scl_level[0], sda_drive_low[1], busy_res[2],
	                                        // done_res[3], read_byte[11:4], slave_nack[12],
	                                        // cmd_rejected[13], zero
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	item_t   in_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	// classify the incoming tick
	i2cm_front u_front (
		.action      (s_axis_tuser),
		.data        (s_axis_tdata[7:0]),
		.master_nack (s_axis_tdata[8]),
		.sda_line    (s_axis_tdata[9]),
		.item        (in_item)
	);

	// decoupling queue
	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_item  (in_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// bus sequencer
	i2cm_back #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// pack result
	assign m_axis_tdata = {2'b00, res.rejected, res.slave_nack, res.read_byte,
		res.done, res.busy, res.sda_low, res.scl};

endmodule
